/* hdl/hough_lane_line_endpoint_defines.svh */
// Assertion macros for the lane-line end-point finder.
`ifndef HOUGH_LANE_LINE_ENDPOINT_DEFINES_SVH
`define HOUGH_LANE_LINE_ENDPOINT_DEFINES_SVH
`ifndef SYNTHESIS
`define HLE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("immediate implication failed");
`define HLE_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define HLE_ASSERT_IMP(name, clk, rst, ante, cons)
`define HLE_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/hle_pkg.sv */
// Types, constants and trig tables for the lane-line end-point finder.
`default_nettype none
package hle_pkg;

  localparam int ANGLE_BINS  = 180;
  localparam int RHO_BINS    = 201;
  localparam int TABLE_DEPTH = ANGLE_BINS * RHO_BINS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VOTE_W      = 13;

  localparam logic [VOTE_W-1:0] VOTE_MAX = 13'd8191;
  localparam logic [7:0] LAST_ANGLE = 8'(ANGLE_BINS - 1);
  localparam logic [7:0] HALF_BINS  = 8'd100;
  localparam logic [7:0] SCAN_LAST_BIN = 8'd199;
  localparam logic [7:0] RIGHT_ANGLE = 8'd90;
  localparam logic [6:0] WINDOW_MAX = 7'd89;
  localparam logic signed [15:0] Y_LIMIT = 16'sd1024;
  localparam logic signed [12:0] RHO_CLAMP = 13'sd100;
  localparam logic signed [7:0] RHO_OK = 8'sd15;
  localparam logic signed [23:0] END_Y_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] END_Y_MIN = 24'sh800000;

  localparam logic CFG_PATH_LENGTH  = 1'b0;
  localparam logic CFG_ANGLE_WINDOW = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK,
    ST_VX, ST_VY, ST_VB1, ST_VB2, ST_VRD, ST_VWR,
    ST_EVAL, ST_SINIT, ST_SCAN, ST_SDRAIN, ST_TRIG, ST_RCHK,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_FAR1, ST_FAR2,
    ST_L1, ST_A1, ST_L2, ST_A2, ST_N1, ST_N2, ST_D1, ST_D2,
    ST_DSET, ST_DIV, ST_FIN, ST_EMIT
  } state_t;

  localparam logic [14:0] SIN_Q14 [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Cosine in Q14 for an angle of 0..179 degrees.
  function automatic logic signed [15:0] cos_of(input logic [7:0] j);
    logic signed [15:0] v;
    if (j <= RIGHT_ANGLE) begin
      v = signed'({1'b0, SIN_Q14[7'(RIGHT_ANGLE - j)]});
    end else begin
      v = -signed'({1'b0, SIN_Q14[7'(j - RIGHT_ANGLE)]});
    end
    return v;
  endfunction

  // Sine in Q14 for an angle of 0..179 degrees; never negative there.
  function automatic logic [14:0] sin_of(input logic [7:0] j);
    logic [14:0] v;
    if (j <= RIGHT_ANGLE) begin
      v = SIN_Q14[j[6:0]];
    end else begin
      v = SIN_Q14[7'(8'd180 - j)];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/hough_lane_line_endpoint.sv */
// Top level of the Hough-transform lane-line end-point finder.
//
// Channel  Direction  Signals                                   Beat carries
// in       sink       in_valid in_ready point_x point_y last_point  one point
// out      source     out_valid out_ready path_found end_y end_x    one result
// cfg      sink       cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// For a voting point, every angle row runs multiply x, multiply-add y, two binning
// steps and a read-modify-write on the one vote memory port. A last point with no
// end point latched yet runs a peak scan unless the window is zero and, if the peaks
// pass their checks, a 52-step division, then a clearing pass over all 36180 cells.
// After reset the same clearing pass runs before the first point. A result waiting
// at the output holds off the next result, and no points are taken while that is held.
`default_nettype none
`include "hough_lane_line_endpoint_defines.svh"
module hough_lane_line_endpoint #(
  parameter int MAX_POINTS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic               last_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    path_found,
  output logic signed [23:0]      end_y,
  output logic [7:0]              end_x,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW = hle_pkg::ADDR_W;
  localparam int QW = 52;

  hle_pkg::state_t state, state_next;

  logic [7:0] path_length;
  logic [6:0] angle_window;
  logic found_latch;
  logic signed [23:0] held_end_y;
  logic [7:0] held_end_x;
  logic [CNT_W-1:0] set_count;
  logic do_clear;

  logic signed [15:0] x_reg, y_reg;
  logic last_reg;
  logic [7:0] j;
  logic [AW-1:0] base, addr;

  logic [hle_pkg::VOTE_W-1:0] vote_mem [0:hle_pkg::TABLE_DEPTH-1];
  logic [hle_pkg::VOTE_W-1:0] rdata, wdata;
  logic mem_we;

  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_p;

  logic signed [31:0] acc;
  logic signed [34:0] t5;
  logic signed [12:0] rq, rc;
  logic [7:0] vbin;

  logic [6:0] w_eff;
  logic [7:0] lo, hi;
  logic [7:0] s_angle, s_bin, d_angle, d_bin;
  logic d_valid;
  logic [hle_pkg::VOTE_W-1:0] best1, best2;
  logic [7:0] t1, t2, bin1, bin2;
  logic signed [7:0] r1, r2;
  logic signed [15:0] c1, c2;
  logic [14:0] s1, s2;
  logic par;

  logic signed [21:0] numr;
  logic signed [31:0] e;
  logic [31:0] ae;
  logic [21:0] an;
  logic [40:0] k;
  logic signed [23:0] l;
  logic signed [26:0] a1, a2;
  logic signed [42:0] n;
  logic [42:0] nmag;
  logic [28:0] d;
  logic [31:0] d10;
  logic neg;
  logic [QW-1:0] quo;
  logic [33:0] rem, remsh;
  logic [32:0] dvs;
  logic [5:0] div_cnt;
  logic sgn;
  logic signed [23:0] end_val;

  logic vote_ok, rho_bad, emit_go;

  assign cfg_ready = 1'b1;

  // Window limited to 89 so the sine at the search edges is never zero.
  assign w_eff = (angle_window > hle_pkg::WINDOW_MAX) ? hle_pkg::WINDOW_MAX : angle_window;
  assign lo = 8'(hle_pkg::RIGHT_ANGLE - 8'(w_eff));
  assign hi = 8'(8'd89 + 8'(w_eff));

  assign vote_ok = !found_latch && (set_count < CNT_W'(MAX_POINTS)) &&
                   (y_reg <= hle_pkg::Y_LIMIT) && (y_reg >= -hle_pkg::Y_LIMIT);
  assign rho_bad = (r1 <= -hle_pkg::RHO_OK) || (r1 >= hle_pkg::RHO_OK) ||
                   (r2 <= -hle_pkg::RHO_OK) || (r2 >= hle_pkg::RHO_OK);
  assign emit_go = !out_valid || out_ready;

  // Shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      hle_pkg::ST_VX: begin
        mul_a = 27'(x_reg);
        mul_b = 17'(hle_pkg::cos_of(j));
      end
      hle_pkg::ST_VY: begin
        mul_a = 27'(y_reg);
        mul_b = signed'(17'(hle_pkg::sin_of(j)));
      end
      hle_pkg::ST_SINIT: begin
        mul_a = signed'(27'(lo));
        mul_b = 17'sd201;
      end
      hle_pkg::ST_M1: begin
        mul_a = 27'(r1);
        mul_b = 17'(c2);
      end
      hle_pkg::ST_M2: begin
        mul_a = 27'(r2);
        mul_b = 17'(c1);
      end
      hle_pkg::ST_M3: begin
        mul_a = signed'(27'(s1));
        mul_b = 17'(c2);
      end
      hle_pkg::ST_M4: begin
        mul_a = signed'(27'(s2));
        mul_b = 17'(c1);
      end
      hle_pkg::ST_L1: begin
        mul_a = signed'(27'(path_length));
        mul_b = 17'(c1);
      end
      hle_pkg::ST_L2: begin
        mul_a = signed'(27'(path_length));
        mul_b = 17'(c2);
      end
      hle_pkg::ST_N1: begin
        mul_a = a1;
        mul_b = signed'(17'(s2));
      end
      hle_pkg::ST_N2: begin
        mul_a = a2;
        mul_b = signed'(17'(s1));
      end
      hle_pkg::ST_D1: begin
        mul_a = signed'(27'(s1));
        mul_b = signed'(17'(s2));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 44'(mul_a) * 44'(mul_b);

  // Rho binning: truncation toward zero was folded into t5 by a bias.
  always_comb begin
    rq = 13'(t5 >>> 22);
    if (rq > hle_pkg::RHO_CLAMP) begin
      rc = hle_pkg::RHO_CLAMP;
    end else if (rq < -hle_pkg::RHO_CLAMP) begin
      rc = -hle_pkg::RHO_CLAMP;
    end else begin
      rc = rq;
    end
    vbin = 8'(rc + hle_pkg::RHO_CLAMP);
  end

  assign ae = e[31] ? 32'(-e) : 32'(e);
  assign an = numr[21] ? 22'(-numr) : 22'(numr);
  assign nmag = n[42] ? 43'(-n) : 43'(n);
  assign remsh = {rem[32:0], quo[QW-1]};
  assign sgn = neg ^ par;

  always_comb begin
    if (!sgn) begin
      end_val = (quo > QW'(hle_pkg::END_Y_MAX)) ? hle_pkg::END_Y_MAX : signed'(quo[23:0]);
    end else begin
      end_val = (quo > QW'(24'h800000)) ? hle_pkg::END_Y_MIN : signed'(24'(-quo));
    end
  end

  // Vote memory.
  assign mem_we = (state == hle_pkg::ST_VWR) || (state == hle_pkg::ST_CLEAR);
  assign wdata = (state == hle_pkg::ST_CLEAR) ? '0 :
                 (rdata == hle_pkg::VOTE_MAX) ? rdata : rdata + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vote_mem[addr] <= wdata;
    end
    rdata <= vote_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hle_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    case (state)
      hle_pkg::ST_CLEAR: begin
        if (addr == AW'(hle_pkg::TABLE_DEPTH - 1)) state_next = hle_pkg::ST_IDLE;
      end
      hle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = hle_pkg::ST_CHECK;
      end
      hle_pkg::ST_CHECK: begin
        if (vote_ok) state_next = hle_pkg::ST_VX;
        else if (last_reg) state_next = hle_pkg::ST_EVAL;
        else state_next = hle_pkg::ST_IDLE;
      end
      hle_pkg::ST_VX:  state_next = hle_pkg::ST_VY;
      hle_pkg::ST_VY:  state_next = hle_pkg::ST_VB1;
      hle_pkg::ST_VB1: state_next = hle_pkg::ST_VB2;
      hle_pkg::ST_VB2: state_next = hle_pkg::ST_VRD;
      hle_pkg::ST_VRD: state_next = hle_pkg::ST_VWR;
      hle_pkg::ST_VWR: begin
        if (j != hle_pkg::LAST_ANGLE) state_next = hle_pkg::ST_VX;
        else if (last_reg) state_next = hle_pkg::ST_EVAL;
        else state_next = hle_pkg::ST_IDLE;
      end
      hle_pkg::ST_EVAL: begin
        if (found_latch || (angle_window == 7'd0)) state_next = hle_pkg::ST_EMIT;
        else state_next = hle_pkg::ST_SINIT;
      end
      hle_pkg::ST_SINIT: state_next = hle_pkg::ST_SCAN;
      hle_pkg::ST_SCAN: begin
        if ((s_bin == hle_pkg::SCAN_LAST_BIN) && (s_angle == hi)) state_next = hle_pkg::ST_SDRAIN;
      end
      hle_pkg::ST_SDRAIN: state_next = hle_pkg::ST_TRIG;
      hle_pkg::ST_TRIG:   state_next = hle_pkg::ST_RCHK;
      hle_pkg::ST_RCHK: begin
        if (rho_bad) state_next = hle_pkg::ST_EMIT;
        else if (par) state_next = hle_pkg::ST_L1;
        else state_next = hle_pkg::ST_M1;
      end
      hle_pkg::ST_M1:   state_next = hle_pkg::ST_M2;
      hle_pkg::ST_M2:   state_next = hle_pkg::ST_M3;
      hle_pkg::ST_M3:   state_next = hle_pkg::ST_M4;
      hle_pkg::ST_M4:   state_next = hle_pkg::ST_FAR1;
      hle_pkg::ST_FAR1: state_next = hle_pkg::ST_FAR2;
      hle_pkg::ST_FAR2: begin
        if (41'({an, 14'd0}) > k) state_next = hle_pkg::ST_L1;
        else state_next = hle_pkg::ST_EMIT;
      end
      hle_pkg::ST_L1:   state_next = hle_pkg::ST_A1;
      hle_pkg::ST_A1:   state_next = hle_pkg::ST_L2;
      hle_pkg::ST_L2:   state_next = hle_pkg::ST_A2;
      hle_pkg::ST_A2:   state_next = hle_pkg::ST_N1;
      hle_pkg::ST_N1:   state_next = hle_pkg::ST_N2;
      hle_pkg::ST_N2:   state_next = hle_pkg::ST_D1;
      hle_pkg::ST_D1:   state_next = hle_pkg::ST_D2;
      hle_pkg::ST_D2:   state_next = hle_pkg::ST_DSET;
      hle_pkg::ST_DSET: state_next = hle_pkg::ST_DIV;
      hle_pkg::ST_DIV: begin
        if (div_cnt == 6'(QW - 1)) state_next = hle_pkg::ST_FIN;
      end
      hle_pkg::ST_FIN: state_next = hle_pkg::ST_EMIT;
      hle_pkg::ST_EMIT: begin
        if (emit_go) state_next = do_clear ? hle_pkg::ST_CLEAR : hle_pkg::ST_IDLE;
      end
      default: state_next = hle_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      path_length  <= 8'd80;
      angle_window <= 7'd1;
      found_latch  <= 1'b0;
      held_end_y   <= '0;
      held_end_x   <= '0;
      set_count    <= '0;
      do_clear     <= 1'b0;
      addr         <= '0;
      d_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          hle_pkg::CFG_PATH_LENGTH:  path_length <= cfg_data;
          hle_pkg::CFG_ANGLE_WINDOW: angle_window <= cfg_data[6:0];
          default: ;
        endcase
      end
      d_valid <= (state == hle_pkg::ST_SCAN);
      if (state == hle_pkg::ST_CHECK && !found_latch && set_count < CNT_W'(MAX_POINTS)) begin
        set_count <= set_count + 1'b1;
      end
      if (state == hle_pkg::ST_EVAL) begin
        do_clear <= !found_latch;
        if (!found_latch) set_count <= '0;
      end
      if (state == hle_pkg::ST_FIN) begin
        found_latch <= 1'b1;
        held_end_y  <= end_val;
        held_end_x  <= path_length;
      end
      case (state)
        hle_pkg::ST_CLEAR: addr <= addr + 1'b1;
        hle_pkg::ST_VB2:   addr <= base + AW'(vbin);
        hle_pkg::ST_SINIT: addr <= AW'(mul_p);
        hle_pkg::ST_SCAN: begin
          if (s_bin == hle_pkg::SCAN_LAST_BIN) addr <= base + AW'(hle_pkg::RHO_BINS);
          else addr <= addr + 1'b1;
        end
        hle_pkg::ST_EMIT: if (emit_go) addr <= '0;
        default: ;
      endcase
      if (state == hle_pkg::ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (state == hle_pkg::ST_EMIT && emit_go) begin
      path_found <= found_latch;
      end_y      <= found_latch ? held_end_y : 24'sd0;
      end_x      <= found_latch ? held_end_x : path_length;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == hle_pkg::ST_IDLE) begin
      x_reg    <= point_x;
      y_reg    <= point_y;
      last_reg <= last_point;
    end
    d_angle <= s_angle;
    d_bin   <= s_bin;
    // Ties go to the later cell in scan order, so compare with >=.
    if (d_valid) begin
      if (d_bin < hle_pkg::HALF_BINS) begin
        if (rdata >= best1) begin
          best1 <= rdata;
          t1    <= d_angle;
          bin1  <= d_bin;
        end
      end else if (rdata >= best2) begin
        best2 <= rdata;
        t2    <= d_angle;
        bin2  <= d_bin;
      end
    end
    case (state)
      hle_pkg::ST_CHECK: begin
        j    <= '0;
        base <= '0;
      end
      hle_pkg::ST_VX: acc <= 32'(mul_p);
      hle_pkg::ST_VY: acc <= acc + 32'(mul_p);
      hle_pkg::ST_VB1: begin
        t5 <= (35'(acc) <<< 2) + 35'(acc) + (acc[31] ? 35'sd4194303 : 35'sd0);
      end
      hle_pkg::ST_VWR: begin
        j    <= j + 1'b1;
        base <= base + AW'(hle_pkg::RHO_BINS);
      end
      hle_pkg::ST_SINIT: begin
        base    <= AW'(mul_p);
        s_angle <= lo;
        s_bin   <= '0;
        best1   <= '0;
        best2   <= '0;
      end
      hle_pkg::ST_SCAN: begin
        if (s_bin == hle_pkg::SCAN_LAST_BIN) begin
          s_bin   <= '0;
          s_angle <= s_angle + 1'b1;
          base    <= base + AW'(hle_pkg::RHO_BINS);
        end else begin
          s_bin <= s_bin + 1'b1;
        end
      end
      hle_pkg::ST_TRIG: begin
        c1  <= hle_pkg::cos_of(t1);
        s1  <= hle_pkg::sin_of(t1);
        c2  <= hle_pkg::cos_of(t2);
        s2  <= hle_pkg::sin_of(t2);
        r1  <= signed'(8'(bin1 - hle_pkg::HALF_BINS));
        r2  <= signed'(8'(bin2 - hle_pkg::HALF_BINS));
        par <= (t1 == t2);
      end
      hle_pkg::ST_M1: numr <= 22'(mul_p);
      hle_pkg::ST_M2: numr <= numr - 22'(mul_p);
      hle_pkg::ST_M3: e <= 32'(mul_p);
      hle_pkg::ST_M4: e <= e - 32'(mul_p);
      // 1000 = 1024 - 32 + 8
      hle_pkg::ST_FAR1: k <= (41'(ae) << 10) - (41'(ae) << 5) + (41'(ae) << 3);
      hle_pkg::ST_L1: l <= 24'(mul_p);
      hle_pkg::ST_A1: a1 <= (27'(r1) <<< 14) - (27'(l) <<< 2) - 27'(l);
      hle_pkg::ST_L2: l <= 24'(mul_p);
      hle_pkg::ST_A2: a2 <= (27'(r2) <<< 14) - (27'(l) <<< 2) - 27'(l);
      hle_pkg::ST_N1: n <= 43'(mul_p);
      hle_pkg::ST_N2: n <= n + 43'(mul_p);
      hle_pkg::ST_D1: d <= 29'(mul_p);
      hle_pkg::ST_D2: d10 <= (32'(d) << 3) + (32'(d) << 1);
      hle_pkg::ST_DSET: begin
        // Rounded quotient of 256*|n| by d10 as (2*256*|n| + d10) / (2*d10).
        neg     <= n[42];
        quo     <= (QW'(nmag) << 9) + QW'(d10);
        dvs     <= {d10, 1'b0};
        rem     <= '0;
        div_cnt <= '0;
      end
      hle_pkg::ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (remsh >= 34'(dvs)) begin
          rem <= remsh - 34'(dvs);
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= remsh;
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  `HLE_ASSERT_NXT(a_latch_holds, clk, rst, found_latch, found_latch)
  `HLE_ASSERT_IMP(a_not_found_zero, clk, rst, out_valid && !path_found, end_y == 24'sd0)
  `HLE_ASSERT_IMP(a_scan_in_table, clk, rst, state == hle_pkg::ST_SCAN, addr < AW'(hle_pkg::TABLE_DEPTH))
  `HLE_ASSERT_IMP(a_busy_no_ready, clk, rst, state == hle_pkg::ST_CLEAR, !in_ready)

endmodule
`default_nettype wire

/* tb/hough_lane_line_endpoint_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Hough-transform lane-line end-point finder.
module hough_lane_line_endpoint_tb;
  import hle_pkg::*;

  localparam int  SET_CAP     = 4096;
  localparam int  BUSY_CYCLES = 40000;
  localparam longint CYCLE_LIMIT = 12000000;

  typedef struct {
    logic              found;
    logic signed [23:0] ey;
    logic [7:0]        ex;
  } endpoint_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               cfg;
    logic [7:0]         len;
    logic [6:0]         win;
    logic               typed;
    endpoint_t          res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic path_found;
  logic signed [23:0] end_y;
  logic [7:0] end_x;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  hough_lane_line_endpoint uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .path_found(path_found), .end_y(end_y), .end_x(end_x),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the block.
  logic [12:0] votes [0:ANGLE_BINS-1][0:RHO_BINS-1];
  logic              latched;
  logic signed [23:0] held_y;
  logic [7:0]        held_x;
  int                set_pts;
  logic [7:0]        cur_len;
  logic [6:0]        cur_win;
  endpoint_t         end_point_q[$];

  int  errors = 0;
  int  n_points = 0;
  int  n_results = 0;
  int  n_found = 0;
  logic quiet = 1'b0;
  longint cycles = 0;

  function automatic longint cos_q14(int j);
    return j <= 90 ? longint'(SIN_Q14[90 - j]) : -longint'(SIN_Q14[j - 90]);
  endfunction

  function automatic longint sin_q14(int j);
    return j <= 90 ? longint'(SIN_Q14[j]) : longint'(SIN_Q14[180 - j]);
  endfunction

  function automatic void clear_votes();
    foreach (votes[i, j]) votes[i][j] = '0;
  endfunction

  function automatic void cast_votes(longint x, longint y);
    longint s;
    longint r;
    for (int j = 0; j < ANGLE_BINS; j++) begin
      s = x * cos_q14(j) + y * sin_q14(j);
      r = (5 * s) / 4194304;
      if (r > 100) r = 100;
      if (r < -100) r = -100;
      if (votes[j][r + 100] != 13'd8191) votes[j][r + 100] = votes[j][r + 100] + 1'b1;
    end
  endfunction

  // Last maximum over the angle range and bin range; ties go to the later cell.
  function automatic void find_peak(int lo, int hi, int b0, int b1,
                                    inout int th, inout int r);
    int best;
    best = 0;
    for (int i = lo; i <= hi; i++) begin
      for (int b = b0; b <= b1; b++) begin
        if (int'(votes[i][b]) >= best) begin
          best = votes[i][b];
          th = i;
          r = b - 100;
        end
      end
    end
  endfunction

  function automatic logic solve_end(output logic signed [23:0] ey);
    int w, lo, hi, t1, t2, r1, r2;
    longint c1, s1, c2, s2, num, e, a1, a2, n, d, un, q, v;
    logic parallel;
    ey = '0;
    w = cur_win;
    if (w == 0) return 1'b0;
    if (w > 89) w = 89;
    lo = 90 - w;
    hi = 90 + w - 1;
    t1 = lo; t2 = lo; r1 = 0; r2 = 0;
    find_peak(lo, hi, 0, 99, t1, r1);
    find_peak(lo, hi, 100, 199, t2, r2);
    if (r1 <= -15 || r1 >= 15 || r2 <= -15 || r2 >= 15) return 1'b0;
    c1 = cos_q14(t1); s1 = sin_q14(t1);
    c2 = cos_q14(t2); s2 = sin_q14(t2);
    parallel = (t1 == t2);
    if (!parallel) begin
      num = (longint'(r1) * c2 - longint'(r2) * c1) * 16384;
      e = s1 * c2 - s2 * c1;
      if (num < 0) num = -num;
      if (e < 0) e = -e;
      if (!(num > 1000 * e)) return 1'b0;
    end
    a1 = longint'(r1) * 16384 - 5 * longint'(cur_len) * c1;
    a2 = longint'(r2) * 16384 - 5 * longint'(cur_len) * c2;
    n = (a1 * s2 + a2 * s1) * 256;
    d = 10 * s1 * s2;
    un = n < 0 ? -n : n;
    q = (2 * un + d) / (2 * d);
    v = n < 0 ? -q : q;
    if (parallel) v = -v;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    ey = v[23:0];
    return 1'b1;
  endfunction

  function automatic void predict_point(logic signed [15:0] x, logic signed [15:0] y,
                                        logic last);
    logic signed [23:0] ey;
    endpoint_t r;
    if (!latched && set_pts < SET_CAP) begin
      set_pts++;
      if (y <= 1024 && y >= -1024) cast_votes(x, y);
    end
    if (last) begin
      if (!latched) begin
        if (solve_end(ey)) begin
          latched = 1'b1;
          held_y = ey;
          held_x = cur_len;
        end
        clear_votes();
        set_pts = 0;
      end
      r.found = latched;
      r.ey = latched ? held_y : 24'sd0;
      r.ex = latched ? held_x : cur_len;
      end_point_q.push_back(r);
    end
  endfunction

  always @(negedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 23);

  always @(posedge clk) begin : check_results
    endpoint_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (path_found) n_found++;
      if (end_point_q.size() == 0) begin
        $display("%0t: result with none pending: found=%0d end_y=%0d end_x=%0d",
                 $time, path_found, end_y, end_x);
        errors++;
      end else begin
        want = end_point_q.pop_front();
        if (path_found !== want.found) begin
          $display("%0t: path_found expected %0d actual %0d", $time, want.found, path_found);
          errors++;
        end
        if (end_y !== want.ey) begin
          $display("%0t: end_y expected %0d actual %0d", $time, want.ey, end_y);
          errors++;
        end
        if (end_x !== want.ex) begin
          $display("%0t: end_x expected %0d actual %0d", $time, want.ex, end_x);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run timed out", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    last_point <= last;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    n_points++;
    predict_point(x, y, last);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_PATH_LENGTH) cur_len = data;
    else cur_win = data[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let every pending result come back, then wait out the clearing pass.
  task automatic settle();
    in_valid <= 1'b0;
    while (end_point_q.size() != 0) @(negedge clk);
    repeat (BUSY_CYCLES) @(negedge clk);
  endtask

  function automatic row_t mk(int x, int y, bit last, bit cfg, int len, int win,
                              bit typed, bit f, int ey, int ex);
    row_t r;
    r.x = x[15:0]; r.y = y[15:0]; r.last = last;
    r.cfg = cfg; r.len = len[7:0]; r.win = win[6:0];
    r.typed = typed; r.res.found = f; r.res.ey = ey[23:0]; r.res.ex = ex[7:0];
    return r;
  endfunction

  function automatic logic signed [15:0] skip_y();
    logic signed [15:0] y;
    y = 16'($urandom);
    if (y >= -1024 && y <= 1024) y = y ^ 16'h4000;
    return y;
  endfunction

  function automatic logic signed [15:0] near_y();
    return 16'($urandom_range(0, 2048) - 1024);
  endfunction

  function automatic logic signed [15:0] any_x();
    return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2560) - 1280);
  endfunction

  row_t tbl[$];

  initial begin
    int n, k, c1, c2, slope, xv;
    logic [7:0] len;
    logic [7:0] win;
    clear_votes();
    latched = 1'b0; held_y = '0; held_x = '0; set_pts = 0;
    cur_len = 8'd80; cur_win = 7'd1;

    // Empty sets search all-zero tables: the upper peak falls on a bin far outside 3 m.
    tbl.push_back(mk(0, 32767, 1, 0, 0, 0, 1, 0, 0, 80));
    tbl.push_back(mk(-32768, -1024, 0, 1, 255, 0, 0, 0, 0, 0));
    tbl.push_back(mk(32767, 1024, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(32767, -1024, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(-32768, 1024, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(0, 1025, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(0, -1025, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(0, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(-1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(256, 384, 0, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(256, -384, 0, 0, 0, 0, 0, 0, 0, 0));
    // A zero window searches nothing, so nothing can be found.
    tbl.push_back(mk(0, 0, 1, 0, 0, 0, 1, 0, 0, 255));
    tbl.push_back(mk(100, -100, 1, 1, 1, 0, 1, 0, 0, 1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (tbl[i]) begin
      if (tbl[i].cfg) begin
        settle();
        write_reg(CFG_PATH_LENGTH, tbl[i].len);
        write_reg(CFG_ANGLE_WINDOW, {1'b0, tbl[i].win});
      end
      send_point(tbl[i].x, tbl[i].y, tbl[i].last);
      if (tbl[i].typed) end_point_q[end_point_q.size() - 1] = tbl[i].res;
    end

    // Random sets of mixed voting and skipped points under changing settings.
    for (int s = 0; s < 18; s++) begin
      if (s % 3 == 0) begin
        settle();
        case (s / 3)
          0: begin len = 8'd255; win = 8'd1; end
          1: begin len = 8'd1; win = 8'd89; end
          2: begin len = 8'($urandom_range(1, 255)); win = 8'd100; end
          3: begin len = 8'($urandom_range(1, 255)); win = 8'd127; end
          default: begin
            len = 8'($urandom_range(1, 255));
            win = 8'($urandom_range(1, 89));
          end
        endcase
        write_reg(CFG_PATH_LENGTH, len);
        write_reg(CFG_ANGLE_WINDOW, win);
      end
      if (s == 10) begin
        // Points past the cap of one set must not vote.
        for (int p = 0; p < SET_CAP; p++) send_point(16'($urandom), skip_y(), 1'b0);
        for (int p = 0; p < 3; p++) send_point(any_x(), near_y(), 1'b0);
        send_point(any_x(), near_y(), 1'b1);
      end else begin
        n = $urandom_range(1, 30);
        for (int p = 0; p < n; p++) begin
          send_point(any_x(), ($urandom_range(0, 99) < 60) ? near_y() : skip_y(),
                     p == n - 1);
        end
      end
    end

    // Two lane lines, parallel or slightly converging, until an end point latches.
    settle();
    write_reg(CFG_PATH_LENGTH, 8'($urandom_range(1, 255)));
    write_reg(CFG_ANGLE_WINDOW, 8'($urandom_range(1, 20)));
    for (int s = 0; s < 12 && !latched; s++) begin
      c1 = -$urandom_range(128, 896);
      c2 = $urandom_range(128, 896);
      slope = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) - 2 : 0;
      n = $urandom_range(5, 8);
      for (int p = 0; p < 2 * n; p++) begin
        xv = $urandom_range(0, 7680);
        k = (p % 2) ? c2 : c1;
        send_point(16'(xv), 16'(k + (xv * slope) / 64), 1'b0);
        if ($urandom_range(0, 9) == 0) send_point(any_x(), skip_y(), 1'b0);
      end
      send_point(any_x(), skip_y(), 1'b1);
    end

    // Once latched, every set just repeats the held end point.
    quiet = 1'b1;
    for (int s = 0; s < 60; s++) begin
      if (s == 20) quiet = 1'b0;
      if (s == 30) begin
        settle();
        write_reg(CFG_PATH_LENGTH, 8'($urandom_range(1, 255)));
        write_reg(CFG_ANGLE_WINDOW, 8'($urandom_range(1, 89)));
      end
      n = $urandom_range(1, 8);
      for (int p = 0; p < n; p++) begin
        send_point(16'($urandom), ($urandom_range(0, 1)) ? near_y() : 16'($urandom),
                   p == n - 1);
      end
    end

    in_valid <= 1'b0;
    while (end_point_q.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);

    $display("Sent %0d points and checked %0d end-point results, %0d with a path found.",
             n_points, n_results, n_found);
    $display("Settings swept path length 1..255 and angle windows 0, 1, 89 and above.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
